### rtl/arb_pkg.sv
package arb_pkg;

    localparam int DEFAULT_SLOTS = 16;
    localparam int MAX_RESULTS = 16;
    localparam int WORD_W = 32;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_SEND = 2'd0;
    localparam kind_t KIND_ACK = 2'd1;
    localparam kind_t KIND_RESEND = 2'd2;

    typedef logic [2:0] status_t;
    localparam status_t ST_SEND = 3'd0;
    localparam status_t ST_RESEND = 3'd1;
    localparam status_t ST_EMPTY = 3'd2;
    localparam status_t ST_ACK_CUR = 3'd3;
    localparam status_t ST_ACK_BUF = 3'd4;
    localparam status_t ST_ACK_NONE = 3'd5;

    typedef struct packed {
        kind_t             kind;
        logic [WORD_W-1:0] msg_id;
        logic [WORD_W-1:0] msg_time;
        logic [WORD_W-1:0] msg_payload;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] out_id;
        logic [WORD_W-1:0] out_time;
        logic [WORD_W-1:0] out_payload;
        logic              overwrote;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [WORD_W-1:0] id;
        logic [WORD_W-1:0] stamp;
        logic [WORD_W-1:0] data;
    } entry_t;

    typedef struct packed {
        logic    capture;
        logic    scan_start;
        logic    advance;
        logic    track;
        logic    clear_chk;
        logic    save;
        logic    set_current;
        logic    clear_current;
        logic    load_out;
        status_t out_status;
        logic    out_last;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  cur_valid;
        logic  cur_match;
        logic  chk_vld;
        logic  chk_slot_valid;
        logic  chk_id_match;
        logic  chk_tail_empty;
        logic  count_at_cap;
        logic  scan_done;
        logic  out_free;
    } dp_sts_t;

endpackage

### rtl/arb_stream_if.sv
interface arb_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

### rtl/ack_retransmit_buffer_core.sv
// Retransmission buffer. Items arrive on the item channel and results leave on the
// result channel; both use valid/ready, and a transfer happens when both are high.
// A send item makes the message current and returns one send result; if the old
// current message was still unacknowledged it is first saved into a buffer slot.
// An ack item returns one result naming where the id matched. A resend item returns
// one result per valid slot in slot order, at most sixteen, or one empty result.
// The block takes one item at a time. A send with an unacknowledged current message
// reads every slot timestamp from the slot memory, one per cycle, to find a free slot
// or the oldest entry before the old message is saved. An ack that misses the
// current message scans the slots the same way and stops at the first valid slot
// whose id matches. A resend scans the slots up to and including its last valid slot
// or the slot of its sixteenth result, or all of them when the buffer is empty.
// An item of the unused kind returns nothing. The last result of an item has last
// set. When the receiver stalls, the result register holds its transfer and the
// scan pauses until it is taken. Reset clears the current message and all slot
// valid bits, so the buffer starts empty; slot contents need no clearing.
module ack_retransmit_buffer_core #(
    parameter int SLOTS = arb_pkg::DEFAULT_SLOTS
) (
    input logic         clk,
    input logic         rst_n,
    arb_stream_if.sink   item,
    arb_stream_if.source result
);

    arb_pkg::dp_cmd_t cmd;
    arb_pkg::dp_sts_t sts;

    arb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    arb_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_payload  (item.payload),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .out_payload (result.payload)
    );

endmodule

### rtl/arb_dp.sv
module arb_dp #(
    parameter int SLOTS = arb_pkg::DEFAULT_SLOTS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  arb_pkg::item_t   in_payload,
    input  arb_pkg::dp_cmd_t cmd,
    output arb_pkg::dp_sts_t sts,
    output logic             out_valid,
    input  logic             out_ready,
    output arb_pkg::result_t out_payload
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int RES_W = $clog2(arb_pkg::MAX_RESULTS + 1);

    arb_pkg::item_t   item_reg;
    arb_pkg::entry_t  cur_reg;
    logic             cur_valid_reg;
    logic [SLOTS-1:0] slot_valid_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             chk_vld_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    arb_pkg::entry_t  rd_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] victim_idx_reg;
    logic [arb_pkg::WORD_W-1:0] victim_stamp_reg;
    logic             overwrote_reg;
    logic [RES_W-1:0] res_cnt_reg;
    logic             out_valid_reg;
    arb_pkg::result_t out_reg;

    arb_pkg::entry_t  mem [SLOTS];

    logic             scan_end;
    logic             rd_en;
    logic [IDX_W-1:0] wr_addr;
    logic [SLOTS-1:0] tail;
    arb_pkg::result_t out_next;

    assign scan_end = (scan_idx_reg == CNT_W'(SLOTS));
    assign rd_en = cmd.advance && !scan_end;
    assign wr_addr = free_found_reg ? free_idx_reg : victim_idx_reg;

    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            tail[j] = slot_valid_reg[j] && (IDX_W'(j) > chk_idx_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.save)
        begin
            mem[wr_addr] <= cur_reg;
        end
        if (rd_en)
        begin
            rd_reg <= mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        out_next = '0;
        out_next.status = cmd.out_status;
        out_next.last = cmd.out_last;
        unique case (cmd.out_status)
            arb_pkg::ST_SEND:
            begin
                out_next.out_id = item_reg.msg_id;
                out_next.out_time = item_reg.msg_time;
                out_next.out_payload = item_reg.msg_payload;
                out_next.overwrote = overwrote_reg;
            end
            arb_pkg::ST_RESEND:
            begin
                out_next.out_id = rd_reg.id;
                out_next.out_time = rd_reg.stamp;
                out_next.out_payload = rd_reg.data;
            end
            arb_pkg::ST_ACK_CUR, arb_pkg::ST_ACK_BUF, arb_pkg::ST_ACK_NONE:
            begin
                out_next.out_id = item_reg.msg_id;
            end
            default:
            begin
                out_next.out_id = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_payload;
        end
        if (cmd.track && chk_vld_reg)
        begin
            if (!slot_valid_reg[chk_idx_reg] && !free_found_reg)
            begin
                free_idx_reg <= chk_idx_reg;
            end
            if (chk_idx_reg == '0 || rd_reg.stamp < victim_stamp_reg)
            begin
                victim_idx_reg <= chk_idx_reg;
                victim_stamp_reg <= rd_reg.stamp;
            end
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cur_reg <= '0;
            slot_valid_reg <= '0;
            scan_idx_reg <= '0;
            chk_vld_reg <= 1'b0;
            chk_idx_reg <= '0;
            free_found_reg <= 1'b0;
            overwrote_reg <= 1'b0;
            res_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                overwrote_reg <= 1'b0;
            end
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                chk_vld_reg <= 1'b0;
                free_found_reg <= 1'b0;
                res_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.advance)
                begin
                    if (!scan_end)
                    begin
                        chk_vld_reg <= 1'b1;
                        chk_idx_reg <= scan_idx_reg[IDX_W-1:0];
                        scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        chk_vld_reg <= 1'b0;
                    end
                end
                if (cmd.track && chk_vld_reg && !slot_valid_reg[chk_idx_reg])
                begin
                    free_found_reg <= 1'b1;
                end
                if (cmd.load_out && cmd.out_status == arb_pkg::ST_RESEND)
                begin
                    res_cnt_reg <= res_cnt_reg + RES_W'(1);
                end
            end
            if (cmd.save)
            begin
                slot_valid_reg[wr_addr] <= 1'b1;
                overwrote_reg <= !free_found_reg;
            end
            if (cmd.clear_chk)
            begin
                slot_valid_reg[chk_idx_reg] <= 1'b0;
            end
            if (cmd.set_current)
            begin
                cur_valid_reg <= 1'b1;
                cur_reg.id <= item_reg.msg_id;
                cur_reg.stamp <= item_reg.msg_time;
                cur_reg.data <= item_reg.msg_payload;
            end
            else if (cmd.clear_current)
            begin
                cur_valid_reg <= 1'b0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.kind = item_reg.kind;
        sts.cur_valid = cur_valid_reg;
        sts.cur_match = (cur_reg.id == item_reg.msg_id);
        sts.chk_vld = chk_vld_reg;
        sts.chk_slot_valid = slot_valid_reg[chk_idx_reg];
        sts.chk_id_match = (rd_reg.id == item_reg.msg_id);
        sts.chk_tail_empty = ~|tail;
        sts.count_at_cap = (res_cnt_reg == RES_W'(arb_pkg::MAX_RESULTS - 1));
        sts.scan_done = !chk_vld_reg && scan_end;
        sts.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_payload = out_reg;

endmodule

### rtl/arb_ctrl.sv
module arb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  arb_pkg::dp_sts_t sts,
    output arb_pkg::dp_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_SAVE   = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    arb_pkg::status_t  code_reg;
    arb_pkg::status_t  code_next;
    logic              resend_last;

    assign in_ready = (state_reg == S_IDLE);
    assign resend_last = sts.chk_tail_empty || sts.count_at_cap;

    always_comb
    begin
        state_next = state_reg;
        code_next = code_reg;
        cmd = '0;
        cmd.out_status = code_reg;
        cmd.out_last = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.scan_start = 1'b1;
                unique case (sts.kind)
                    arb_pkg::KIND_SEND:
                    begin
                        code_next = arb_pkg::ST_SEND;
                        state_next = sts.cur_valid ? S_SCAN : S_EMIT;
                    end
                    arb_pkg::KIND_ACK:
                    begin
                        if (sts.cur_match)
                        begin
                            code_next = arb_pkg::ST_ACK_CUR;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    arb_pkg::KIND_RESEND:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                unique case (sts.kind)
                    arb_pkg::KIND_SEND:
                    begin
                        cmd.advance = 1'b1;
                        cmd.track = 1'b1;
                        if (sts.scan_done)
                        begin
                            state_next = S_SAVE;
                        end
                    end
                    arb_pkg::KIND_ACK:
                    begin
                        if (sts.chk_vld && sts.chk_slot_valid && sts.chk_id_match)
                        begin
                            cmd.clear_chk = 1'b1;
                            code_next = arb_pkg::ST_ACK_BUF;
                            state_next = S_EMIT;
                        end
                        else if (sts.scan_done)
                        begin
                            code_next = arb_pkg::ST_ACK_NONE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (sts.chk_vld && sts.chk_slot_valid)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.load_out = 1'b1;
                                cmd.out_status = arb_pkg::ST_RESEND;
                                cmd.out_last = resend_last;
                                cmd.advance = 1'b1;
                                if (resend_last)
                                begin
                                    state_next = S_IDLE;
                                end
                            end
                        end
                        else if (sts.scan_done)
                        begin
                            code_next = arb_pkg::ST_EMPTY;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                        end
                    end
                endcase
            end
            S_SAVE:
            begin
                cmd.save = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.set_current = (code_reg == arb_pkg::ST_SEND);
                    cmd.clear_current = (code_reg == arb_pkg::ST_ACK_CUR);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg <= arb_pkg::ST_SEND;
        end
        else
        begin
            state_reg <= state_next;
            code_reg <= code_next;
        end
    end

endmodule

### dv/ack_retransmit_buffer_core_test.sv
module ack_retransmit_buffer_core_test;
    import arb_pkg::*;

    localparam int SLOTS = 16;
    localparam kind_t KIND_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 4 * SLOTS + 40;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;

    arb_stream_if #(.payload_t(item_t)) item_ch ();
    arb_stream_if #(.payload_t(result_t)) result_ch ();

    ack_retransmit_buffer_core #(.SLOTS(SLOTS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_ch),
        .result(result_ch)
    );

    // Mirror of the block's message state.
    logic   cur_valid;
    entry_t cur_msg;
    logic   slot_valid [SLOTS];
    entry_t slot_msg [SLOTS];

    result_t           owed_reports[$];
    logic [WORD_W-1:0] recent_ids[$];
    logic [WORD_W-1:0] stamp_clock;
    int                mismatches;
    int                cycles;
    int                stall_left;
    bit                idling;
    logic              hold_results;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic item_t make_item(kind_t kind, logic [WORD_W-1:0] id,
                                        logic [WORD_W-1:0] stamp,
                                        logic [WORD_W-1:0] data);
        item_t it;
        it.kind = kind;
        it.msg_id = id;
        it.msg_time = stamp;
        it.msg_payload = data;
        return it;
    endfunction

    task automatic buffer_step(input item_t it);
        result_t r;
        result_t held;
        int      victim;
        int      n;
        bit      found;
        r = '0;
        held = '0;
        n = 0;
        found = 1'b0;
        case (it.kind)
            KIND_SEND:
            begin
                if (cur_valid)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!found && !slot_valid[i])
                        begin
                            slot_valid[i] = 1'b1;
                            slot_msg[i] = cur_msg;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                    begin
                        victim = 0;
                        for (int i = 1; i < SLOTS; i++)
                        begin
                            if (slot_msg[i].stamp < slot_msg[victim].stamp)
                                victim = i;
                        end
                        slot_msg[victim] = cur_msg;
                        r.overwrote = 1'b1;
                    end
                end
                cur_valid = 1'b1;
                cur_msg.id = it.msg_id;
                cur_msg.stamp = it.msg_time;
                cur_msg.data = it.msg_payload;
                r.status = ST_SEND;
                r.out_id = it.msg_id;
                r.out_time = it.msg_time;
                r.out_payload = it.msg_payload;
                r.last = 1'b1;
                owed_reports.push_back(r);
            end
            KIND_ACK:
            begin
                r.out_id = it.msg_id;
                r.last = 1'b1;
                if (cur_msg.id == it.msg_id)
                begin
                    cur_valid = 1'b0;
                    r.status = ST_ACK_CUR;
                end
                else
                begin
                    r.status = ST_ACK_NONE;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!found && slot_valid[i] && slot_msg[i].id == it.msg_id)
                        begin
                            slot_valid[i] = 1'b0;
                            r.status = ST_ACK_BUF;
                            found = 1'b1;
                        end
                    end
                end
                owed_reports.push_back(r);
            end
            KIND_RESEND:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_valid[i] && n < MAX_RESULTS)
                    begin
                        if (n > 0)
                            owed_reports.push_back(held);
                        held = '0;
                        held.status = ST_RESEND;
                        held.out_id = slot_msg[i].id;
                        held.out_time = slot_msg[i].stamp;
                        held.out_payload = slot_msg[i].data;
                        n++;
                    end
                end
                if (n == 0)
                begin
                    r.status = ST_EMPTY;
                    r.last = 1'b1;
                    owed_reports.push_back(r);
                end
                else
                begin
                    held.last = 1'b1;
                    owed_reports.push_back(held);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Offers one item and waits for its transfer; the mirror is updated at that edge.
    task automatic send_item(input item_t it);
        item_ch.valid <= 1'b1;
        item_ch.payload <= it;
        do
            @(posedge clk);
        while (!item_ch.ready);
        buffer_step(it);
        if (it.kind == KIND_SEND)
        begin
            recent_ids.push_back(it.msg_id);
            if (recent_ids.size() > 40)
                void'(recent_ids.pop_front());
        end
        if (idling && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    function automatic logic [WORD_W-1:0] pick_id();
        if (recent_ids.size() > 0 && $urandom_range(0, 9) < 7)
            return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 40);
        return $urandom;
    endfunction

    function automatic item_t next_random_item();
        int                choice;
        logic [WORD_W-1:0] stamp;
        choice = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0, 1: stamp = $urandom;
            2: stamp = stamp_clock;
            default:
            begin
                stamp_clock = stamp_clock + $urandom_range(0, 1000);
                stamp = stamp_clock;
            end
        endcase
        if (choice < 45)
            return make_item(KIND_SEND, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40)
                                                                    : $urandom,
                             stamp, $urandom);
        if (choice < 80)
            return make_item(KIND_ACK, pick_id(), $urandom, $urandom);
        if (choice < 95)
            return make_item(KIND_RESEND, $urandom, $urandom, $urandom);
        return make_item(KIND_UNUSED, pick_id(), $urandom, $urandom);
    endfunction

    task automatic test_empty_buffer();
        send_item(make_item(KIND_RESEND, 32'h0, 32'h0, 32'h0));
        // The current id resets to zero, so acking zero hits the cleared current message.
        send_item(make_item(KIND_ACK, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_ack_paths();
        send_item(make_item(KIND_SEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(KIND_SEND, 32'h0, 32'h0, 32'h0));
        send_item(make_item(KIND_ACK, 32'hFFFF_FFFF, 32'h0, 32'h0));
        send_item(make_item(KIND_ACK, 32'h0, 32'h0, 32'h0));
        send_item(make_item(KIND_ACK, 32'h0, 32'h0, 32'h0));
        send_item(make_item(KIND_ACK, 32'h5A5A_0001, 32'h0, 32'h0));
        send_item(make_item(KIND_RESEND, 32'hFFFF_FFFF, 32'h0, 32'h0));
    endtask

    // Fills every slot, then forces one eviction among tied oldest stamps.
    task automatic test_full_buffer();
        for (int i = 0; i <= SLOTS + 1; i++)
            send_item(make_item(KIND_SEND, 32'h100 + i,
                                (i % 3 == 0) ? 32'd7 : 32'd1000 - i, 32'hA000_0000 | i));
        send_item(make_item(KIND_RESEND, 32'h0, 32'h0, 32'h0));
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_item(next_random_item());
    endtask

    task automatic test_result_backpressure();
        bit saved;
        saved = idling;
        idling = 1'b0;
        fork
            begin
                hold_results <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results <= 1'b0;
            end
        join_none
        test_random_traffic(30);
        idling = saved;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        got = result_ch.payload;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (owed_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d id %h time %h payload %h",
                             got.status, got.out_id, got.out_time, got.out_payload);
            end
            else
            begin
                want = owed_reports.pop_front();
                if (got.status !== want.status || got.out_id !== want.out_id ||
                    got.out_time !== want.out_time || got.out_payload !== want.out_payload ||
                    got.overwrote !== want.overwrote || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("expected: status %0d id %h time %h payload %h ovw %b last %b",
                                 want.status, want.out_id, want.out_time, want.out_payload,
                                 want.overwrote, want.last);
                        $display("actual:   status %0d id %h time %h payload %h ovw %b last %b",
                                 got.status, got.out_id, got.out_time, got.out_payload,
                                 got.overwrote, got.last);
                    end
                end
            end
        end
        if (hold_results)
            result_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.payload = '0;
        result_ch.ready = 1'b0;
        hold_results = 1'b0;
        idling = 1'b1;
        stall_left = 0;
        mismatches = 0;
        cycles = 0;
        stamp_clock = $urandom;
        cur_valid = 1'b0;
        cur_msg = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_msg[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_buffer();
        test_ack_paths();
        test_full_buffer();
        test_random_traffic(220);
        test_result_backpressure();
        idling = 1'b0;
        test_random_traffic(180);
        item_ch.valid <= 1'b0;
        while (owed_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
